>>> hdl/iba_pkg.sv
// ----------------------------------------------------------------------------
// iba_pkg: shared types and codes for the integer ALU core
// Command codes, pipeline stage word and operand width.
// ----------------------------------------------------------------------------
package iba_pkg;

    localparam int DataW = 32;
    localparam int CmdW  = 5;

    typedef logic [CmdW-1:0]  cmd_t;
    typedef logic [DataW-1:0] data_t;

    localparam cmd_t CmdAdd  = 5'd0;
    localparam cmd_t CmdSub  = 5'd1;
    localparam cmd_t CmdMul  = 5'd2;
    localparam cmd_t CmdDiv  = 5'd3;
    localparam cmd_t CmdMod  = 5'd4;
    localparam cmd_t CmdEq   = 5'd5;
    localparam cmd_t CmdNe   = 5'd6;
    localparam cmd_t CmdLt   = 5'd7;
    localparam cmd_t CmdLe   = 5'd8;
    localparam cmd_t CmdGt   = 5'd9;
    localparam cmd_t CmdGe   = 5'd10;
    localparam cmd_t CmdLand = 5'd11;
    localparam cmd_t CmdLor  = 5'd12;
    localparam cmd_t CmdShr  = 5'd13;
    localparam cmd_t CmdShl  = 5'd14;
    localparam cmd_t CmdAnd  = 5'd15;
    localparam cmd_t CmdOr   = 5'd16;
    localparam cmd_t CmdXor  = 5'd17;

    // Word carried down the divider stages.
    typedef struct packed {
        logic         is_div;   // quotient wanted, else remainder
        logic         is_dz;    // divide by zero
        logic         q_neg;
        logic         r_neg;
        data_t        rem;      // partial remainder
        data_t        quo;      // dividend shifting out / quotient shifting in
        data_t        dvs;      // divisor magnitude
        data_t        other;    // result of non-division commands
    } div_word_t;

endpackage

>>> hdl/integer_binary_op_alu_core.sv
// ----------------------------------------------------------------------------
// integer_binary_op_alu_core: pipelined 32-bit signed ALU
// Eighteen operations; division by a restoring pipeline of radix-2 stages.
// ----------------------------------------------------------------------------
// One word in and one word out per cycle while the output is taken. Every
// command passes one input stage (decode, magnitudes, simple operations,
// multiplier partial products), 32 divider stages of one quotient bit each,
// and the output register, with the sign fix in front of the output register.
// The divider chain sets the depth; the 32x32 multiply is cut into a low
// 16x16 product and two 16x16 cross products in the input stage and summed in
// the next. All stages advance together on a global enable that drops only
// when the output word is held and not taken, so a stall loses and repeats
// nothing. Unused commands give 0, status 0.
module integer_binary_op_alu_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [31:0]    s_left_operand,
    input  logic signed [31:0]    s_right_operand,
    input  logic [4:0]            s_command,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [31:0]    m_result_value,
    output logic                  m_status
);
    import iba_pkg::*;

    localparam int NStg = DataW;

    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // ---------------- input stage ----------------
    div_word_t s0_next;
    logic      s0_mul;
    logic [31:0] mlo_next, mhi_next;
    data_t     ua, ub;
    logic      lt;

    always_comb begin
        ua = s_left_operand[31]  ? 32'(-s_left_operand)  : s_left_operand;
        ub = s_right_operand[31] ? 32'(-s_right_operand) : s_right_operand;
        lt = s_left_operand < s_right_operand;
        s0_next        = '0;
        s0_next.is_div = (s_command == CmdDiv);
        s0_next.is_dz  = (s_right_operand == '0);
        s0_next.q_neg  = s_left_operand[31] ^ s_right_operand[31];
        s0_next.r_neg  = s_left_operand[31];
        s0_next.quo    = ua;
        s0_next.dvs    = ub;
        case (s_command)
            CmdAdd:  s0_next.other = s_left_operand + s_right_operand;
            CmdSub:  s0_next.other = s_left_operand - s_right_operand;
            CmdEq:   s0_next.other = 32'(s_left_operand == s_right_operand);
            CmdNe:   s0_next.other = 32'(s_left_operand != s_right_operand);
            CmdLt:   s0_next.other = 32'(lt);
            CmdLe:   s0_next.other = 32'(lt || s_left_operand == s_right_operand);
            CmdGt:   s0_next.other = 32'(!lt && s_left_operand != s_right_operand);
            CmdGe:   s0_next.other = 32'(!lt);
            CmdLand: s0_next.other = 32'(s_left_operand != '0 && s_right_operand != '0);
            CmdLor:  s0_next.other = 32'(s_left_operand != '0 || s_right_operand != '0);
            CmdShr:  s0_next.other = s_left_operand >>> s_right_operand[4:0];
            CmdShl:  s0_next.other = s_left_operand << s_right_operand[4:0];
            CmdAnd:  s0_next.other = s_left_operand & s_right_operand;
            CmdOr:   s0_next.other = s_left_operand | s_right_operand;
            CmdXor:  s0_next.other = s_left_operand ^ s_right_operand;
            default: s0_next.other = '0;
        endcase
        s0_mul   = (s_command == CmdMul);
        // low 32 bits of a*b = lo*lo + ((hi_a*lo_b + lo_a*hi_b) << 16)
        mlo_next = s_left_operand[15:0] * s_right_operand[15:0];
        mhi_next = 32'(s_left_operand[31:16] * s_right_operand[15:0])
                 + 32'(s_left_operand[15:0] * s_right_operand[31:16]);
    end

    // ---------------- stage registers ----------------
    logic      vld_reg  [NStg+1];
    logic      dvm_reg  [NStg+1];   // command is div or mod
    div_word_t stg_reg  [NStg+1];
    logic [31:0] mlo_reg, mhi_reg;
    logic      mul_reg;
    div_word_t stg_next [NStg+1];

    always_comb begin
        stg_next[0] = s0_next;
        for (int i = 0; i < NStg; i++) begin
            logic [32:0] trial;
            div_word_t w;
            w     = stg_reg[i];
            trial = {w.rem, w.quo[31]} - {1'b0, w.dvs};
            if (!trial[32]) begin
                w.rem = trial[31:0];
                w.quo = {w.quo[30:0], 1'b1};
            end else begin
                w.rem = {w.rem[30:0], w.quo[31]};
                w.quo = {w.quo[30:0], 1'b0};
            end
            stg_next[i+1] = w;
        end
        // Sum the product in stage one; it then rides in the other slot.
        if (mul_reg)
            stg_next[1].other = mlo_reg + {mhi_reg[15:0], 16'h0000};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NStg + 1; i++) vld_reg[i] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < NStg + 1; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dvm_reg[0] <= (s_command == CmdDiv) || (s_command == CmdMod);
            for (int i = 1; i < NStg + 1; i++) dvm_reg[i] <= dvm_reg[i-1];
            stg_reg[0] <= stg_next[0];
            mlo_reg    <= mlo_next;
            mhi_reg    <= mhi_next;
            mul_reg    <= s0_mul;
            for (int i = 1; i <= NStg; i++) stg_reg[i] <= stg_next[i];
        end
    end

    // ---------------- sign fix and output ----------------
    div_word_t   fin;
    logic signed [31:0] res_next;
    logic        st_next;
    logic        out_vld_reg;
    logic signed [31:0] res_reg;
    logic        st_reg;

    always_comb begin
        fin      = stg_reg[NStg];
        st_next  = 1'b0;
        res_next = fin.other;
        if (dvm_reg[NStg]) begin
            if (fin.is_dz) begin
                st_next  = 1'b1;
                res_next = '0;
            end else if (fin.is_div) begin
                res_next = fin.q_neg ? -fin.quo : fin.quo;
            end else begin
                res_next = fin.r_neg ? -fin.rem : fin.rem;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= vld_reg[NStg];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg <= res_next;
            st_reg  <= st_next;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_result_value = res_reg;
    assign m_status       = st_reg;

    // ---------------- assertions ----------------
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_result_value) && $stable(m_status)))
        else $error("output word changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_ready == (!m_valid || m_ready)))
        else $error("ready not tied to output stage");
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_result_value == 0))
        else $error("divide by zero with non-zero result");
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && vld_reg[NStg]) |=> m_valid)
        else $error("word lost at output stage");
endmodule
